>>> hw/rtl/note_tone_generator_assert.svh
// Assertion macros for the tone generator.
// Each macro takes a label, an antecedent and a consequent, sampled on clk and
// disabled during rst.
`ifndef NOTE_TONE_GENERATOR_ASSERT_SVH
`define NOTE_TONE_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define NTG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ntg assertion failed");
`define NTG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ntg assertion failed");
`else
`define NTG_ASSERT_NOW(label, ante, cons)
`define NTG_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/ntg_pkg.sv
package ntg_pkg;

  localparam int TempoW   = 16;
  localparam int LimitW   = 21;
  localparam int PeriodW  = 11;
  localparam int ElapsedW = 22;
  localparam int LenW     = 5;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 21;

  localparam logic [TempoW-1:0] TempoReset = 16'd20000;
  localparam logic [LimitW-1:0] LimitReset = 21'd640000;
  localparam logic [7:0]        EndByte    = 8'hFF;

  localparam logic [4:0] ToneFirst = 5'd1;
  localparam logic [4:0] ToneLast  = 5'd24;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTempoUnit = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgPlayLimit = 1'd1;

  typedef struct packed {
    logic [TempoW-1:0] tempo_unit;
    logic [LimitW-1:0] play_limit;
  } ntg_cfg_t;

  typedef struct packed {
    logic pin;
    logic busy;
    logic done;
  } ntg_res_t;

  // period in ticks for each tone code; zero for rests and unused codes
  function automatic logic [PeriodW-1:0] tone_period_of(input logic [4:0] code);
    logic [PeriodW-1:0] p;
    case (code)
      5'd1:    p = 11'd1911;
      5'd2:    p = 11'd1804;
      5'd3:    p = 11'd1703;
      5'd4:    p = 11'd1607;
      5'd5:    p = 11'd1517;
      5'd6:    p = 11'd1432;
      5'd7:    p = 11'd1352;
      5'd8:    p = 11'd1276;
      5'd9:    p = 11'd1204;
      5'd10:   p = 11'd1136;
      5'd11:   p = 11'd1073;
      5'd12:   p = 11'd1012;
      5'd13:   p = 11'd955;
      5'd14:   p = 11'd902;
      5'd15:   p = 11'd851;
      5'd16:   p = 11'd803;
      5'd17:   p = 11'd758;
      5'd18:   p = 11'd716;
      5'd19:   p = 11'd676;
      5'd20:   p = 11'd638;
      5'd21:   p = 11'd602;
      5'd22:   p = 11'd568;
      5'd23:   p = 11'd536;
      5'd24:   p = 11'd506;
      default: p = '0;
    endcase
    return p;
  endfunction

  // note length in units for each length code
  function automatic logic [LenW-1:0] length_of(input logic [2:0] code);
    logic [LenW-1:0] l;
    case (code)
      3'd0:    l = 5'd2;
      3'd1:    l = 5'd4;
      3'd2:    l = 5'd6;
      3'd3:    l = 5'd8;
      3'd4:    l = 5'd12;
      3'd5:    l = 5'd16;
      3'd6:    l = 5'd18;
      default: l = 5'd24;
    endcase
    return l;
  endfunction

endpackage

>>> hw/rtl/ntg_voice.sv
module ntg_voice import ntg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     cmd,
  input  logic [7:0] note,
  input  ntg_cfg_t cfg,
  output ntg_res_t res
);

  logic [PeriodW-1:0]  half_period, half_period_next;
  logic [PeriodW-1:0]  tone_period, tone_period_next;
  logic [PeriodW-1:0]  phase_count, phase_count_next;
  logic                high_phase, high_phase_next;
  logic [ElapsedW-1:0] elapsed, elapsed_next;
  logic [ElapsedW-1:0] target, target_next;
  logic                is_rest, is_rest_next;
  logic                playing, playing_next;
  logic                done;

  // load decode
  logic [4:0]          code;
  logic [LenW-1:0]     len;
  logic [LimitW-1:0]   tgt;
  logic [PeriodW-1:0]  new_period;
  logic                is_tone;
  logic                load_ok;

  // tick arithmetic
  logic [ElapsedW-1:0] el_step;
  logic [ElapsedW-1:0] el_cycle;
  logic [PeriodW-1:0]  ph_step;

  assign code       = note[4:0];
  assign len        = length_of(note[7:5]);
  assign tgt        = LimitW'(len) * LimitW'(cfg.tempo_unit);
  assign new_period = tone_period_of(code);
  assign is_tone    = (code >= ToneFirst) && (code <= ToneLast);
  assign load_ok    = !playing && (note != EndByte) && (tgt < cfg.play_limit) && (tgt != '0);

  assign el_step  = elapsed + ElapsedW'(1);
  assign el_cycle = elapsed + ElapsedW'(tone_period);
  assign ph_step  = phase_count + PeriodW'(1);

  // next state for the item in the input stage
  always_comb begin
    half_period_next = half_period;
    tone_period_next = tone_period;
    phase_count_next = phase_count;
    high_phase_next  = high_phase;
    elapsed_next     = elapsed;
    target_next      = target;
    is_rest_next     = is_rest;
    playing_next     = playing;
    done             = 1'b0;
    if (!cmd) begin
      if (load_ok) begin
        target_next      = ElapsedW'(tgt);
        elapsed_next     = '0;
        phase_count_next = '0;
        playing_next     = 1'b1;
        is_rest_next     = !is_tone;
        tone_period_next = new_period;
        half_period_next = new_period >> 1;
        high_phase_next  = is_tone;
      end
    end else if (playing) begin
      if (is_rest) begin
        // rest: silent for twice the target, one count per tick
        elapsed_next = el_step;
        if ({1'b0, el_step} >= {target, 1'b0}) begin
          playing_next = 1'b0;
          is_rest_next = 1'b0;
          done         = 1'b1;
        end
      end else begin
        phase_count_next = ph_step;
        if ({1'b0, ph_step} >= {half_period, 1'b0}) begin
          phase_count_next = '0;
          if (high_phase) begin
            high_phase_next = 1'b0;
          end else begin
            // end of a full cycle: account the period
            elapsed_next = el_cycle;
            if (el_cycle >= target) begin
              playing_next = 1'b0;
              done         = 1'b1;
            end else begin
              high_phase_next = 1'b1;
            end
          end
        end
      end
    end
  end

  assign res.pin  = playing_next && !is_rest_next && high_phase_next;
  assign res.busy = playing_next;
  assign res.done = done;

  // commit state when the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= '0;
      tone_period <= '0;
      phase_count <= '0;
      high_phase  <= 1'b0;
      elapsed     <= '0;
      target      <= '0;
      is_rest     <= 1'b0;
      playing     <= 1'b0;
    end else if (adv) begin
      half_period <= half_period_next;
      tone_period <= tone_period_next;
      phase_count <= phase_count_next;
      high_phase  <= high_phase_next;
      elapsed     <= elapsed_next;
      target      <= target_next;
      is_rest     <= is_rest_next;
      playing     <= playing_next;
    end
  end

endmodule

>>> hw/rtl/ntg_out_stage.sv
module ntg_out_stage import ntg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  ntg_res_t res,
  input  logic     out_stall,
  output logic     out_free,
  output logic     out_valid,
  output logic     pin,
  output logic     busy_res,
  output logic     note_done
);

  ntg_res_t held;

  // free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      held <= res;
    end
  end

  assign pin       = held.pin;
  assign busy_res  = held.busy;
  assign note_done = held.done;

endmodule

>>> hw/rtl/note_tone_generator.sv
// Items pass through the input register and then the result register, which loads
// an item's result only when it has room.
// Throughput: one item per cycle unless out_stall holds the result register; the
// voice state update is a single pass. Reset (rst, synchronous): voice idle,
// tempo_unit 20000, play_limit 640000, both item registers empty.
`include "note_tone_generator_assert.svh"

module note_tone_generator import ntg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  input  logic [7:0]          note,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                pin,
  output logic                busy_res,
  output logic                note_done,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  ntg_cfg_t   cfg;
  ntg_res_t   res;
  logic       s1_valid;
  logic       s1_cmd;
  logic [7:0] s1_note;
  logic       out_free;
  logic       adv;
  logic       accept;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tempo_unit <= TempoReset;
      cfg.play_limit <= LimitReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgTempoUnit: cfg.tempo_unit <= cfg_data[TempoW-1:0];
        CfgPlayLimit: cfg.play_limit <= cfg_data[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // input stage: advance into the result register when it has room
  assign adv      = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd  <= cmd;
      s1_note <= note;
    end
  end

  ntg_voice u_voice (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .cmd  (s1_cmd),
    .note (s1_note),
    .cfg  (cfg),
    .res  (res)
  );

  ntg_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (adv),
    .res       (res),
    .out_stall (out_stall),
    .out_free  (out_free),
    .out_valid (out_valid),
    .pin       (pin),
    .busy_res  (busy_res),
    .note_done (note_done)
  );

  `NTG_ASSERT_NOW(a_pin_busy, out_valid && pin, busy_res)
  `NTG_ASSERT_NOW(a_done_idle, out_valid && note_done, !busy_res && !pin)
  `NTG_ASSERT_NOW(a_stall_full, in_stall, s1_valid && out_valid)
  `NTG_ASSERT_NEXT(a_adv_result, adv, out_valid)

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ntg_pkg::*;

  localparam int unsigned CycleLimit   = 3_000_000;
  localparam int unsigned RandomItems  = 220;
  localparam int unsigned MaxRounds    = 8;
  localparam int unsigned SeqPerPhase  = 3;
  localparam int unsigned TickCap      = 300_000;
  localparam int unsigned MaxPrinted   = 100;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdTick = 1'b1;

  // period in ticks per tone code, zero marks a rest
  localparam logic [PeriodW-1:0] PeriodTable [0:24] = '{
    0, 1911, 1804, 1703, 1607, 1517, 1432, 1352, 1276, 1204, 1136, 1073, 1012,
    955, 902, 851, 803, 758, 716, 676, 638, 602, 568, 536, 506
  };
  localparam int unsigned LenUnits [0:7] = '{2, 4, 6, 8, 12, 16, 18, 24};

  // tempo and limit settings walked by the random part
  localparam int NumPhases = 6;
  localparam logic [CfgDataW-1:0] PhaseTempo [0:NumPhases-1] = '{
    1, 3, 60, 2, 16'hFFFF, 7
  };
  localparam logic [CfgDataW-1:0] PhaseLimit [0:NumPhases-1] = '{
    21'h1FFFFF, 40, 1000, 640000, 131070, 200
  };

  // Predict the pin, busy and done levels of the voice for each item
  class voice_scoreboard;
    logic [TempoW-1:0]   tempo_unit;
    logic [LimitW-1:0]   play_limit;
    logic [PeriodW-1:0]  half_period;
    logic [PeriodW-1:0]  tone_period;
    logic [PeriodW-1:0]  phase_count;
    logic [ElapsedW-1:0] elapsed;
    logic [ElapsedW-1:0] target;
    logic                high_phase;
    logic                is_rest;
    logic                playing;
    ntg_res_t            levels_q[$];
    int unsigned         mismatches;

    function new();
      tempo_unit  = TempoReset;
      play_limit  = LimitReset;
      half_period = '0;
      tone_period = '0;
      phase_count = '0;
      elapsed     = '0;
      target      = '0;
      high_phase  = 1'b0;
      is_rest     = 1'b0;
      playing     = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgTempoUnit) begin
        tempo_unit = data[TempoW-1:0];
      end else if (idx == CfgPlayLimit) begin
        play_limit = data[LimitW-1:0];
      end
    endfunction

    // Advance the voice by one accepted item and queue the expected levels
    function void accept_item(logic c, logic [7:0] b);
      ntg_res_t            lv;
      logic                done;
      logic [4:0]          code;
      logic [ElapsedW-1:0] tgt;
      done = 1'b0;
      code = b[4:0];
      tgt  = ElapsedW'(LenUnits[b[7:5]] * tempo_unit);
      if (c == CmdLoad) begin
        // drop loads while busy, end markers, and targets out of range
        if (!playing && b != EndByte && tgt != '0 && tgt < ElapsedW'(play_limit)) begin
          target      = tgt;
          elapsed     = '0;
          phase_count = '0;
          playing     = 1'b1;
          if (code >= ToneFirst && code <= ToneLast) begin
            is_rest     = 1'b0;
            tone_period = PeriodTable[code];
            half_period = tone_period >> 1;
            high_phase  = 1'b1;
          end else begin
            is_rest     = 1'b1;
            tone_period = '0;
            half_period = '0;
            high_phase  = 1'b0;
          end
        end
      end else if (playing) begin
        if (is_rest) begin
          // silent rest: one unit of elapsed per tick, ends at twice the target
          elapsed = elapsed + 1'b1;
          if ({1'b0, elapsed} >= {target, 1'b0}) begin
            playing = 1'b0;
            is_rest = 1'b0;
            done    = 1'b1;
          end
        end else begin
          phase_count = phase_count + 1'b1;
          if ({1'b0, phase_count} >= {half_period, 1'b0}) begin
            phase_count = '0;
            if (high_phase) begin
              high_phase = 1'b0;
            end else begin
              // full cycle over: account the period, end or start a new high half
              elapsed = elapsed + ElapsedW'(tone_period);
              if (elapsed >= target) begin
                playing = 1'b0;
                done    = 1'b1;
              end else begin
                high_phase = 1'b1;
              end
            end
          end
        end
      end
      lv.pin  = playing && !is_rest && high_phase;
      lv.busy = playing;
      lv.done = done;
      levels_q.push_back(lv);
    endfunction

    task report(string msg);
      if (mismatches < MaxPrinted) $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    // Compare one accepted result against the oldest expectation
    task check_levels(logic p, logic b, logic d);
      ntg_res_t want;
      if (levels_q.size() == 0) begin
        report($sformatf("unexpected result pin %b busy %b done %b", p, b, d));
        return;
      end
      want = levels_q.pop_front();
      if (p !== want.pin) report($sformatf("pin %b, want %b", p, want.pin));
      if (b !== want.busy) report($sformatf("busy_res %b, want %b", b, want.busy));
      if (d !== want.done) report($sformatf("note_done %b, want %b", d, want.done));
    endtask
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic                cmd       = CmdTick;
  logic [7:0]          note      = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                pin;
  logic                busy_res;
  logic                note_done;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = CfgTempoUnit;
  logic [CfgDataW-1:0] cfg_data  = '0;

  voice_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_mode  = 0;

  note_tone_generator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .note      (note),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pin       (pin),
    .busy_res  (busy_res),
    .note_done (note_done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("note_tone_generator test failed");
      $finish;
    end
  end

  // Stall the result side in changing modes: open, light, heavy, periodic
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cycle_count % 3 == 0);
    endcase
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_levels(pin, busy_res, note_done);
  end

  // Send one item, opening a new burst after a random gap when the last one ran out
  task send_item(logic c, logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        4:          gap = $urandom_range(15, 40);
        default:    gap = $urandom_range(1, 5);
      endcase
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    note     <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.accept_item(c, b);
    items_sent++;
    burst_left--;
  endtask

  // Hold off the sender until every expected result has come back
  task settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.levels_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers while the block is idle
  task set_voice_cfg(logic [CfgDataW-1:0] tempo_data, logic [CfgDataW-1:0] limit_data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= CfgTempoUnit;
    cfg_data  <= tempo_data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(CfgTempoUnit, tempo_data);
    cfg_index <= CfgPlayLimit;
    cfg_data  <= limit_data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(CfgPlayLimit, limit_data);
    cfg_valid <= 1'b0;
  endtask

  // Tick until the current note ends or the tick budget runs out; noisy mode
  // mixes in stray loads and may give up early
  task play_out(bit noisy, int unsigned cap);
    int unsigned ticks;
    ticks = 0;
    while (sb.playing && ticks < cap) begin
      if (noisy && $urandom_range(0, 99) < 3) begin
        send_item(CmdLoad, 8'($urandom_range(0, 255)));
      end else begin
        send_item(CmdTick, 8'($urandom_range(0, 255)));
        ticks++;
      end
      if (noisy && $urandom_range(0, 1999) == 0) break;
    end
  endtask

  initial begin
    int unsigned  round;
    int unsigned  phase;
    int unsigned  seq;
    int unsigned  random_start;
    logic [4:0]   code;
    logic [7:0]   b;

    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // idle tick and end marker at reset settings
    send_item(CmdTick, 8'h00);
    send_item(CmdLoad, EndByte);
    send_item(CmdTick, 8'hFF);

    // shortest units; upper data bits of the tempo write are dropped
    set_voice_cfg(21'h1F0001, 21'h1FFFFF);
    send_item(CmdLoad, 8'h00);
    send_item(CmdLoad, EndByte);
    send_item(CmdLoad, 8'h5A);
    play_out(1'b0, TickCap);
    send_item(CmdLoad, 8'hF9);
    play_out(1'b0, TickCap);
    send_item(CmdLoad, 8'h18);
    play_out(1'b0, TickCap);

    // limit just above one target and below another
    set_voice_cfg(21'd1, 21'd3);
    send_item(CmdLoad, 8'h21);
    send_item(CmdTick, 8'h00);
    send_item(CmdLoad, 8'h1F);
    play_out(1'b0, TickCap);

    // zero tempo gives a zero target
    set_voice_cfg(21'd0, 21'h1FFFFF);
    send_item(CmdLoad, 8'h01);
    send_item(CmdTick, 8'h00);

    // largest tempo against the smallest and a tight limit
    set_voice_cfg(21'h00FFFF, 21'd1);
    send_item(CmdLoad, 8'h0C);
    send_item(CmdTick, 8'h00);
    set_voice_cfg(21'h00FFFF, 21'd131070);
    send_item(CmdLoad, 8'h0C);
    send_item(CmdLoad, 8'h2C);

    // random note sequences across the settings, short tick runs per note
    random_start = items_sent;
    for (round = 0; round < MaxRounds; round++) begin
      for (phase = 0; phase < NumPhases; phase++) begin
        set_voice_cfg(PhaseTempo[phase], PhaseLimit[phase]);
        for (seq = 0; seq < SeqPerPhase; seq++) begin
          if ($urandom_range(0, 19) == 0) settle();
          if ($urandom_range(0, 99) < 10) begin
            send_item(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
          end else begin
            if ($urandom_range(0, 99) < 45) begin
              code = 5'($urandom_range(ToneFirst, ToneLast));
            end else begin
              code = 5'($urandom_range(0, 7));
              if (code != 5'd0) code = code + ToneLast;
            end
            b = {3'($urandom_range(0, 7)), code};
            send_item(CmdLoad, b);
            play_out(1'b1, $urandom_range(4, 24));
          end
        end
        if (items_sent - random_start >= RandomItems) break;
      end
      if (items_sent - random_start >= RandomItems) break;
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.levels_q.size() == 0) begin
      $display("note_tone_generator test passed");
    end else begin
      $display("note_tone_generator test failed");
    end
    $finish;
  end

endmodule
